// ----- rtl/ctxbc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctxbc_pkg: shared types and constants for the chained table-XOR byte cipher
// Holds the 256-entry key table, result kinds and the result-queue sizing.
// ----------------------------------------------------------------------------
package ctxbc_pkg;

  localparam int ByteW     = 8;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Key table index is the frame position plus this offset, mod 256
  localparam logic [ByteW-1:0] RomOffset = 8'd10;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_CSUM    = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_val;
    kind_t            kind;
    logic             ok;
    logic             last;
  } item_t;

  localparam logic [ByteW-1:0] ChainRom [256] = '{
    8'h2f,8'h97,8'h65,8'hd8,8'h19,8'hfc,8'h0c,8'ha1,8'hc3,8'h2c,8'h38,8'h2d,8'h32,8'he3,8'h42,8'hbe,
    8'hb2,8'h12,8'hec,8'h61,8'h25,8'hde,8'h50,8'h18,8'h9c,8'h16,8'h37,8'h24,8'hdc,8'hea,8'h0f,8'h13,
    8'hca,8'h63,8'heb,8'h96,8'h0e,8'h06,8'h9a,8'hda,8'hd1,8'hb4,8'he6,8'h77,8'h86,8'h7c,8'h3c,8'h05,
    8'hbb,8'hd4,8'h8c,8'h51,8'h68,8'h60,8'h73,8'h21,8'h30,8'h55,8'hdf,8'h84,8'h39,8'h8f,8'hcc,8'h9d,
    8'h3d,8'ha3,8'h8d,8'h94,8'h7d,8'h92,8'h56,8'hb0,8'h9b,8'h43,8'h1d,8'h3a,8'h11,8'h74,8'h75,8'hce,
    8'hd3,8'hc7,8'hf6,8'h98,8'had,8'hf1,8'h95,8'h20,8'h5e,8'h8e,8'hd2,8'h5f,8'h69,8'hed,8'h7b,8'ha2,
    8'hab,8'h47,8'hb8,8'h46,8'h04,8'h31,8'hf9,8'h29,8'hd5,8'h4c,8'he4,8'hdd,8'h6e,8'h10,8'hdb,8'h53,
    8'h48,8'h79,8'haa,8'h14,8'hbf,8'h85,8'h52,8'h41,8'h58,8'h99,8'he7,8'h7a,8'h76,8'h70,8'h6b,8'h4b,
    8'ha6,8'h4e,8'h1a,8'h9f,8'hc1,8'hf5,8'h80,8'hfa,8'hc8,8'h02,8'hbc,8'hf7,8'ha9,8'h6c,8'hb6,8'ha7,
    8'hc6,8'hf2,8'h1f,8'hba,8'hf8,8'h67,8'he2,8'hc4,8'h40,8'h23,8'hff,8'h33,8'he5,8'h3e,8'h72,8'he9,
    8'h66,8'h5a,8'ha5,8'h17,8'h35,8'hac,8'h54,8'h28,8'ha8,8'he8,8'hc2,8'hf0,8'hc9,8'he1,8'h0d,8'h87,
    8'h4d,8'h7f,8'h59,8'hd7,8'h8b,8'hfd,8'hb1,8'ha4,8'hb9,8'h4a,8'hcf,8'h44,8'hf3,8'h81,8'h6d,8'h57,
    8'h83,8'h15,8'h2a,8'hb5,8'h45,8'hee,8'h08,8'h7e,8'h00,8'h34,8'haf,8'h6a,8'hf4,8'h03,8'hcb,8'h8a,
    8'hef,8'hbd,8'h01,8'ha0,8'h27,8'h3f,8'h09,8'h90,8'h07,8'h22,8'hfb,8'hd9,8'hc0,8'h5b,8'h4f,8'hd0,
    8'h2e,8'h3b,8'h36,8'h5c,8'h1b,8'h49,8'h6f,8'h9e,8'h89,8'h82,8'hb3,8'h26,8'h1c,8'h2b,8'h0b,8'h62,
    8'h88,8'h0a,8'hfe,8'he0,8'h93,8'h1e,8'hc5,8'h78,8'h71,8'h5d,8'hcd,8'hb7,8'hd6,8'hae,8'h91,8'h64
  };

endpackage

// ----- rtl/chained_table_xor_byte_cipher_top.sv -----
// ----------------------------------------------------------------------------
// chained_table_xor_byte_cipher_top: chained table-XOR byte cipher
// Encodes or decodes frame bytes chained on the previous cipher byte and a
// key table entry; appends or checks an XOR checksum of the plaintext.
// ----------------------------------------------------------------------------
// Results are registered in the result queue and presented from its head.
// Throughput: one item per cycle while in_tready is high; an encode frame end
//   yields two results and the four-slot result queue drains one per cycle
//   while out_tready is high, so in_tready needs two free slots.
// Reset (rst_n low, synchronous): mode to encode, chain state and queue clear.
module chained_table_xor_byte_cipher_top
  import ctxbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,     // [0] mode
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] in_byte
  input  logic       in_tlast,     // frame_end
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] out_byte
  output logic [7:0] out_tuser,    // [1:0] item_kind, [2] check_ok, [7:3] zero
  output logic       out_tlast     // run_last
);

  logic                 mode_r;
  logic [ByteW-1:0]     prev_r, prev_nxt;
  logic [ByteW-1:0]     check_r, check_nxt;
  logic [ByteW-1:0]     pos_r, pos_nxt;
  logic                 in_frame_r, in_frame_nxt;

  item_t                slot_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QueueCntW-1:0] count_r, count_nxt;

  logic                 in_acc, out_acc;
  logic [ByteW-1:0]     rom_idx, key, chained, new_check;
  item_t                item0, item1;
  logic [1:0]           n_push;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign in_tready = (count_r <= QueueCntW'(QueueDepth - 2));

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Chain one byte against the previous cipher byte and the key table
  assign rom_idx = pos_r + RomOffset;
  assign key     = ChainRom[rom_idx];
  assign chained = in_frame_r ? (in_tdata ^ prev_r ^ key) : in_tdata;

  always_comb begin
    prev_nxt     = prev_r;
    check_nxt    = check_r;
    pos_nxt      = pos_r;
    in_frame_nxt = in_frame_r;
    new_check    = '0;
    item0        = '{byte_val: '0, kind: KIND_DATA, ok: 1'b0, last: 1'b1};
    item1        = '{byte_val: '0, kind: KIND_CSUM, ok: 1'b0, last: 1'b1};
    n_push       = 2'd0;
    if (in_acc) begin
      n_push = 2'd1;
      if (mode_r) begin
        // decode: last byte is the received checksum
        if (in_tlast) begin
          item0.kind   = KIND_VERDICT;
          item0.ok     = (in_tdata == check_r);
          prev_nxt     = '0;
          check_nxt    = '0;
          pos_nxt      = '0;
          in_frame_nxt = 1'b0;
        end else begin
          item0.byte_val = chained;
          prev_nxt       = in_tdata;
          check_nxt      = check_r ^ chained;
          pos_nxt        = pos_r + 8'd1;
          in_frame_nxt   = 1'b1;
        end
      end else begin
        new_check      = check_r ^ in_tdata;
        item0.byte_val = chained;
        if (in_tlast) begin
          // encode: append the checksum after the last byte
          n_push         = 2'd2;
          item0.last     = 1'b0;
          item1.byte_val = new_check;
          prev_nxt       = '0;
          check_nxt      = '0;
          pos_nxt        = '0;
          in_frame_nxt   = 1'b0;
        end else begin
          prev_nxt     = chained;
          check_nxt    = new_check;
          pos_nxt      = pos_r + 8'd1;
          in_frame_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      check_r    <= '0;
      pos_r      <= '0;
      in_frame_r <= 1'b0;
    end else begin
      prev_r     <= prev_nxt;
      check_r    <= check_nxt;
      pos_r      <= pos_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

  // Result queue: push up to two items, pop one
  assign count_nxt = count_r + QueueCntW'(n_push) - QueueCntW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QueuePtrW'(n_push);
      rd_ptr_r <= rd_ptr_r + QueuePtrW'(out_acc);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slot_r[wr_ptr_r] <= item0;
    end
    if (n_push == 2'd2) begin
      slot_r[wr_ptr_r + QueuePtrW'(1)] <= item1;
    end
  end

  // Drive the head of the queue
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = slot_r[rd_ptr_r].byte_val;
  assign out_tuser  = {5'd0, slot_r[rd_ptr_r].ok, slot_r[rd_ptr_r].kind};
  assign out_tlast  = slot_r[rd_ptr_r].last;

  // Queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QueueCntW'(QueueDepth))
    else $error("result queue overflow");

  // Frame end returns all chain state to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (pos_r == '0 && check_r == '0 && prev_r == '0 && !in_frame_r))
    else $error("chain state not cleared at frame end");

  // A verdict carries a zero byte and ends its run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] == KIND_VERDICT) |-> (out_tdata == '0 && out_tlast))
    else $error("malformed verdict item");

endmodule
